// File: src/assert_macros.svh
// Assertion macros included by the vertex transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: src/vtpd_pkg.sv
// Package with the state type of the vertex transform block.
package vtpd_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} state_t;
endpackage

// File: src/vertex_transform_perspective_divide.sv
// A matrix write is taken while idle and leaves the block idle. A vertex beat goes through a read setup
// state, multiply-accumulate over all 16 matrix elements, a divide of each coordinate by w in turn on
// the bit-serial divider shared by the coordinates, and a load into the output register.
// No new beat is taken until the previous vertex result has been loaded into the output register.
// Reset clears the per-entry written bits so the matrix reads as identity, and clears all control.
`include "assert_macros.svh"
module vertex_transform_perspective_divide #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// mode, elem_index, elem_value, vertex_x, vertex_y, vertex_z
	input  logic [8*((5+4*COORD_WIDTH+7)/8)-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// out_x, out_y, out_z
	output logic [8*((3*COORD_WIDTH+7)/8)-1:0] m_tdata,
	// overflow
	output logic                     m_tuser
);
	import vtpd_pkg::*;
	localparam int CW = COORD_WIDTH;
	localparam int AW = 2*CW + 4;
	localparam int NW = AW - FRAC_BITS;
	localparam int DW = NW + FRAC_BITS;
	localparam int QCW = $clog2(DW + 2);
	localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

	state_t state_q, state_d;
	logic [CW-1:0] mem [16];
	logic [15:0] wr_q;
	logic [CW-1:0] rd_s1;
	logic [3:0] rd_idx_s1;
	logic [1:0] row_q, col_q;
	logic [CW-1:0] vx_q, vy_q, vz_q;
	logic signed [AW-1:0] acc_q;
	logic signed [NW-1:0] w_q, num_q [3];
	logic [1:0] div_row_q;
	logic [QCW-1:0] bit_q;
	logic [DW-1:0] dn_q, dq_q;
	logic [DW:0] rem_q;
	logic [NW-1:0] dd_q;
	logic dneg_q;
	logic [CW-1:0] res_q [3];
	logic ovf_q;
	logic rd_ok_s1;
	logic out_v_q;
	logic [3*CW-1:0] out_data_q;
	logic out_ovf_q;
	logic load_out;

	logic mode;
	logic [3:0] idx;
	logic [CW-1:0] ev, ix, iy, iz;
	assign mode = s_tdata[0];
	assign idx  = s_tdata[4:1];
	assign ev   = s_tdata[5 +: CW];
	assign ix   = s_tdata[5+CW +: CW];
	assign iy   = s_tdata[5+2*CW +: CW];
	assign iz   = s_tdata[5+3*CW +: CW];

	logic take;
	assign s_tready = (state_q == ST_IDLE);
	assign take = s_tvalid && s_tready;
	assign load_out = (state_q == ST_OUT) && (!out_v_q || m_tready);

	always_ff @(posedge clk) begin
		if (take && !mode) begin
			mem[idx] <= ev;
		end
		rd_s1 <= mem[{col_q, row_q}];
		rd_idx_s1 <= {col_q, row_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else if (take && !mode) begin
			wr_q[idx] <= 1'b1;
		end
	end

	logic [CW-1:0] elem;
	always_comb begin
		if (wr_q[rd_idx_s1]) begin
			elem = rd_s1;
		end else if (rd_idx_s1[3:2] == rd_idx_s1[1:0]) begin
			elem = ONE;
		end else begin
			elem = '0;
		end
	end

	logic signed [AW-1:0] term;
	logic [CW-1:0] vsel;
	logic signed [2*CW-1:0] prod;
	always_comb begin
		case (rd_idx_s1[3:2])
			2'd0: vsel = vx_q;
			2'd1: vsel = vy_q;
			2'd2: vsel = vz_q;
			default: vsel = '0;
		endcase
	end

	assign prod = $signed(elem) * $signed(vsel);

	always_comb begin
		if (rd_idx_s1[3:2] == 2'd3) begin
			term = AW'($signed(elem)) <<< FRAC_BITS;
		end else begin
			term = AW'(prod);
		end
	end

	logic signed [AW-1:0] acc_n;
	logic signed [NW-1:0] dot;
	assign acc_n = acc_q + term;
	assign dot = NW'(acc_n >>> FRAC_BITS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take && mode) state_d = ST_READ;
			ST_READ: state_d = ST_MAC;
			ST_MAC: if (rd_ok_s1 && rd_idx_s1[3:2] == 2'd3 && rd_idx_s1[1:0] == 2'd2)
					state_d = ST_DIV;
			ST_DIV: if (bit_q == QCW'(DW + 1) && div_row_q == 2'd2) state_d = ST_OUT;
			ST_OUT: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic [DW:0] rem_sh, rem_sub;
	logic [NW-1:0] nabs;
	logic [DW-1:0] qv;
	logic [CW-1:0] sat;
	logic sat_ovf;
	always_comb begin
		rem_sh = {rem_q[DW-1:0], dn_q[DW-1]};
		rem_sub = rem_sh - (DW+1)'(dd_q);
		nabs = num_q[div_row_q][NW-1] ? NW'(-num_q[div_row_q]) : num_q[div_row_q];
		qv = dq_q;
		sat_ovf = 1'b0;
		if (!dneg_q) begin
			if (qv > DW'({1'b0, {(CW-1){1'b1}}})) begin
				sat = {1'b0, {(CW-1){1'b1}}};
				sat_ovf = 1'b1;
			end else begin
				sat = qv[CW-1:0];
			end
		end else begin
			if (qv > DW'({1'b1, {(CW-1){1'b0}}})) begin
				sat = {1'b1, {(CW-1){1'b0}}};
				sat_ovf = 1'b1;
			end else begin
				sat = CW'(-qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			rd_ok_s1 <= 1'b0;
			div_row_q <= '0;
			bit_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (take && mode) begin
						vx_q <= ix;
						vy_q <= iy;
						vz_q <= iz;
						row_q <= 2'd3;
						col_q <= 2'd0;
						ovf_q <= 1'b0;
					end
					rd_ok_s1 <= 1'b0;
				end
				ST_READ, ST_MAC: begin
					rd_ok_s1 <= 1'b1;
					if (col_q == 2'd3) begin
						col_q <= 2'd0;
						row_q <= (row_q == 2'd3) ? 2'd0 : row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
					if (rd_ok_s1) begin
						if (rd_idx_s1[3:2] == 2'd0) begin
							acc_q <= term;
						end else begin
							acc_q <= acc_n;
						end
						if (rd_idx_s1[3:2] == 2'd3) begin
							if (rd_idx_s1[1:0] == 2'd3) begin
								w_q <= (dot == '0) ? NW'($signed(ONE)) : dot;
							end else begin
								num_q[rd_idx_s1[1:0]] <= dot;
							end
						end
					end
					div_row_q <= '0;
					bit_q <= '0;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						dn_q <= DW'(nabs) << FRAC_BITS;
						dd_q <= w_q[NW-1] ? NW'(-w_q) : w_q;
						dneg_q <= num_q[div_row_q][NW-1] ^ w_q[NW-1];
						rem_q <= '0;
						dq_q <= '0;
						bit_q <= bit_q + QCW'(1);
					end else if (bit_q == QCW'(DW + 1)) begin
						res_q[div_row_q] <= sat;
						ovf_q <= ovf_q | sat_ovf;
						div_row_q <= div_row_q + 2'd1;
						bit_q <= '0;
					end else begin
						dn_q <= dn_q << 1;
						if (!rem_sub[DW]) begin
							rem_q <= rem_sub;
							dq_q <= {dq_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							dq_q <= {dq_q[DW-2:0], 1'b0};
						end
						bit_q <= bit_q + QCW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {res_q[2], res_q[1], res_q[0]};
			out_ovf_q <= ovf_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = $bits(m_tdata)'(out_data_q);
	assign m_tuser = out_ovf_q;

	`ASSERT_IMPLIES(a_busy_no_ready, clk, arst_n, state_q != ST_IDLE, !s_tready)
	`ASSERT_NEXT(a_vertex_starts, clk, arst_n, take && mode, state_q == ST_READ)
	`ASSERT_NEXT(a_write_stays_idle, clk, arst_n, take && !mode, state_q == ST_IDLE)
	`ASSERT_IMPLIES(a_div_row_range, clk, arst_n, state_q == ST_DIV, div_row_q != 2'd3)
endmodule

// File: bench/vertex_transform_perspective_divide_checker.sv
// Checker for the vertex transform block: predicts every result and compares it with the output.
module vertex_transform_perspective_divide_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           waiting
);
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        ovf;
	} vertex_out_t;

	logic signed [31:0] matrix [16];
	vertex_out_t projected_q [$];

	function automatic logic signed [127:0] row_dot(int r, logic signed [31:0] x,
		logic signed [31:0] y, logic signed [31:0] z);
		logic signed [127:0] acc;
		acc = matrix[r];
		acc = acc * x;
		acc = acc + 128'(signed'(matrix[4+r])) * y + 128'(signed'(matrix[8+r])) * z;
		acc = acc + (128'(signed'(matrix[12+r])) <<< 16);
		return acc >>> 16;
	endfunction

	function automatic logic [31:0] divide_sat(logic signed [127:0] num,
		logic signed [127:0] w, inout logic ovf);
		logic neg;
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		neg = (num < 0) != (w < 0);
		n = num <<< 16;
		if (num < 0) n = -n;
		d = (w < 0) ? -w : w;
		q = n / d;
		if (!neg) begin
			if (q > 128'h7fff_ffff) begin
				ovf = 1'b1;
				return 32'h7fff_ffff;
			end
			return q[31:0];
		end
		if (q > 128'h8000_0000) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return -q[31:0];
	endfunction

	function automatic vertex_out_t project(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		vertex_out_t r;
		logic signed [127:0] w;
		logic ovf;
		ovf = 1'b0;
		w = row_dot(3, x, y, z);
		if (w == 0) w = 128'sd65536;
		r.x = divide_sat(row_dot(0, x, y, z), w, ovf);
		r.y = divide_sat(row_dot(1, x, y, z), w, ovf);
		r.z = divide_sat(row_dot(2, x, y, z), w, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	assign waiting = projected_q.size();

	always @(posedge clk or negedge arst_n) begin
		vertex_out_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
			projected_q.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (projected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: x=%h y=%h z=%h ovf=%b",
							m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
				end else begin
					e = projected_q.pop_front();
					if (e.x !== m_tdata[31:0] || e.y !== m_tdata[63:32] ||
						e.z !== m_tdata[95:64] || e.ovf !== m_tuser) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected x=%h y=%h z=%h ovf=%b, got x=%h y=%h z=%h ovf=%b",
								e.x, e.y, e.z, e.ovf, m_tdata[31:0], m_tdata[63:32],
								m_tdata[95:64], m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tdata[0])
					projected_q.push_back(project(s_tdata[68:37], s_tdata[100:69],
						s_tdata[132:101]));
				else
					matrix[s_tdata[4:1]] = s_tdata[36:5];
			end
		end
	end
endmodule

// File: bench/vertex_transform_perspective_divide_tb.sv
// Testbench top for the vertex transform block: stimulus, flow control and verdict.
module vertex_transform_perspective_divide_tb;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	int           fail_count;
	int           waiting;
	int           burst_left = 0;
	int           vertex_count = 0;
	int           write_count = 0;
	logic         hold_request = 1'b0;

	always #2 clk = ~clk;

	vertex_transform_perspective_divide u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	vertex_transform_perspective_divide_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .waiting(waiting)
	);

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 4))
			0, 1: return $urandom();
			2: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
			3: return 32'($urandom_range(0, 32'h200_0000)) - 32'h100_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0001_0000;
					3: return 32'hffff_0000;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	task automatic send(logic mode, logic [3:0] idx, logic [31:0] val, logic [31:0] x,
		logic [31:0] y, logic [31:0] z);
		s_tdata <= {3'b0, z, y, x, val, idx, mode};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (mode) vertex_count++;
		else write_count++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_elem(logic [3:0] idx, logic [31:0] val);
		send(1'b0, idx, val, $urandom(), $urandom(), $urandom());
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send(1'b1, 4'($urandom()), $urandom(), x, y, z);
	endtask

	initial begin
		logic [31:0] onehot;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			onehot = $urandom_range(0, 3);
			if (onehot == 0) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 99) < 60);
		end
	end

	initial begin
		#12_000_000;
		$display("vertex_transform_perspective_divide test failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0);
		send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
		write_elem(4'd15, 32'h0);
		send_vertex(32'h0003_0000, 32'hfffe_8000, 32'h0000_4000);
		write_elem(4'd15, 32'h0000_0100);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		write_elem(4'd15, 32'hffff_0000);
		send_vertex(32'h0005_0000, 32'h8000_0000, 32'h0001_0000);
		write_elem(4'd12, 32'h7fff_ffff);
		write_elem(4'd13, 32'h8000_0000);
		write_elem(4'd14, 32'h0000_0001);
		send_vertex(32'h0, 32'h0, 32'h0);
		write_elem(4'd3, 32'h0001_0000);
		write_elem(4'd15, 32'h0);
		send_vertex(32'h0, 32'h0001_0000, 32'h0);
		send_vertex(32'h0002_0000, 32'h0, 32'h0);
		for (int i = 0; i < 16; i++) write_elem(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
		for (int n = 0; n < 1660; n++) begin
			if (n == 800) hold_request = 1'b1;
			if ($urandom_range(0, 99) < 30) write_elem(4'($urandom()), pick_value());
			else send_vertex(pick_value(), pick_value(), pick_value());
		end
		s_tvalid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d vertices and %0d matrix element writes, with zero w, saturation",
			vertex_count, write_count);
		$display("and a long output stall exercised along the way.");
		if (fail_count == 0) begin
			$display("vertex_transform_perspective_divide test passed");
		end else begin
			$display("vertex_transform_perspective_divide test failed");
		end
		$finish;
	end
endmodule
